FILE: design/sha256_block_hasher_core_defines.svh
// Assertion macros shared by the SHA-256 block hasher RTL.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef SHA256_BLOCK_HASHER_CORE_DEFINES_SVH
`define SHA256_BLOCK_HASHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define SHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define SHB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHB_ASSERT(lbl, prop, msg)
`define SHB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/shb_pkg.sv
// Shared types, constants and round functions of the SHA-256 block hasher.
// No dependencies; shb_queue, shb_front, shb_back and the core import it.
`timescale 1ns / 1ps
`default_nettype none

package shb_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int WORD_IDX_W  = $clog2(BLOCK_WORDS);
  localparam int HASH_WORDS  = 8;
  localparam int HASH_IDX_W  = $clog2(HASH_WORDS);
  localparam int ROUNDS      = 64;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int QUEUE_DEPTH = 2;

  typedef logic [WORD_W-1:0] shb_word_t;
  typedef logic [0:HASH_WORDS-1][WORD_W-1:0] shb_hash_t;

  // Standard initial hash value
  localparam shb_hash_t SHB_IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Round constants
  localparam shb_word_t SHB_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // One queued job: reload the chaining value, compress a block, emit the digest
  typedef struct packed {
    logic init;
    logic compress;
    logic emit;
  } shb_cmd_t;

  // Front to queue: word write and job push
  typedef struct packed {
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_word;
    shb_word_t             wr_data;
    logic                  push;
    shb_cmd_t              cmd;
  } shb_front_req_t;

  // Back to queue: word read and job pop
  typedef struct packed {
    logic [WORD_IDX_W-1:0] rd_word;
    logic                  pop;
  } shb_back_req_t;

  // Queue occupancy
  typedef struct packed {
    logic full;
    logic empty;
  } shb_q_stat_t;

  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_PREP  = 5'b00010,
    BK_ROUND = 5'b00100,
    BK_FINAL = 5'b01000,
    BK_EMIT  = 5'b10000
  } shb_back_state_t;

  function automatic shb_word_t rotr(input shb_word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic shb_word_t bsig0(input shb_word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic shb_word_t bsig1(input shb_word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic shb_word_t ssig0(input shb_word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic shb_word_t ssig1(input shb_word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

FILE: design/shb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module shb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/shb_queue.sv
// Block queue between front and back: a RAM of block slots plus job flags.
// Depends on shb_pkg and shb_ram.
`timescale 1ns / 1ps
`default_nettype none

module shb_queue import shb_pkg::*; #(
  parameter int QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire shb_front_req_t front_req,
  input  wire shb_back_req_t  back_req,
  output shb_q_stat_t         q_stat,
  output shb_cmd_t            head_cmd,
  output shb_word_t           rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = PTR_W + WORD_IDX_W;

  logic [PTR_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [PTR_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  shb_cmd_t         cmd_r [QUEUE_DEPTH];

  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_cmd     = cmd_r[rd_slot_r];

  // Advance slot pointers and occupancy
  always_comb begin
    wr_slot_nxt = wr_slot_r + PTR_W'(front_req.push);
    rd_slot_nxt = rd_slot_r + PTR_W'(back_req.pop);
    count_nxt   = count_r + CNT_W'(front_req.push) - CNT_W'(back_req.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      count_r   <= '0;
    end else begin
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      count_r   <= count_nxt;
    end
  end

  // Hold job flags of each slot
  always_ff @(posedge clk) begin
    if (front_req.push) begin
      cmd_r[wr_slot_r] <= front_req.cmd;
    end
  end

  // Block words, one slot of sixteen words per queued job
  shb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH * BLOCK_WORDS)
  ) u_blk_ram (
    .clk     (clk),
    .wr_en   (front_req.wr_en),
    .wr_addr ({wr_slot_r, front_req.wr_word}),
    .wr_data (front_req.wr_data),
    .rd_addr (AW'({rd_slot_r, back_req.rd_word})),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

FILE: design/shb_front.sv
// Front end: takes message word beats, places them in a block slot and
// classifies each beat into a queued job. Depends on shb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shb_front import shb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire shb_word_t   in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire shb_q_stat_t q_stat,
  output shb_front_req_t   front_req
);

  logic [WORD_IDX_W-1:0] pos_r, pos_nxt;
  logic                  pend_init_r, pend_init_nxt;
  logic                  accept;
  logic [WORD_IDX_W-1:0] pos_eff;
  logic                  blk_done;
  logic                  init_flag;

  // Stall only while every block slot is owned by the back end
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Classify the beat
  always_comb begin
    pos_eff   = in_tuser ? '0 : pos_r;
    blk_done  = (pos_eff == WORD_IDX_W'(BLOCK_WORDS - 1));
    init_flag = pend_init_r || in_tuser;

    front_req.wr_en        = accept;
    front_req.wr_word      = pos_eff;
    front_req.wr_data      = in_tdata;
    front_req.push         = accept && (blk_done || in_tlast);
    front_req.cmd.init     = init_flag;
    front_req.cmd.compress = blk_done;
    front_req.cmd.emit     = in_tlast;

    pos_nxt       = pos_r;
    pend_init_nxt = pend_init_r;
    if (accept) begin
      pos_nxt       = in_tlast ? '0 : pos_eff + 1'b1;
      pend_init_nxt = front_req.push ? 1'b0 : init_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      pend_init_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      pend_init_r <= pend_init_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/shb_back.sv
// Back end: compression engine, one SHA-256 round per cycle, and the digest
// output beats. Depends on shb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shb_back import shb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire shb_q_stat_t q_stat,
  input  wire shb_cmd_t    head_cmd,
  input  wire shb_word_t   rd_data,
  output shb_back_req_t    back_req,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output shb_word_t        out_tdata,
  output logic             out_tlast
);

  shb_back_state_t       state_r, state_nxt;
  logic [ROUND_W-1:0]    round_r, round_nxt;
  logic [HASH_IDX_W-1:0] idx_r, idx_nxt;
  shb_cmd_t              cmd_r, cmd_nxt;
  shb_hash_t             cv_r, cv_nxt;
  shb_hash_t             v_r, v_nxt;
  shb_word_t             sw_r [BLOCK_WORDS];
  shb_word_t             sw_nxt [BLOCK_WORDS];
  shb_word_t             w_sched, w_t, t1, t2, ch, maj;
  logic                  last_idx;

  assign last_idx   = (idx_r == HASH_IDX_W'(HASH_WORDS - 1));
  assign out_tvalid = (state_r == BK_EMIT);
  assign out_tdata  = cv_r[idx_r];
  assign out_tlast  = last_idx;

  // Schedule word and round terms
  always_comb begin
    w_sched = ssig1(sw_r[BLOCK_WORDS-2]) + sw_r[BLOCK_WORDS-7] + ssig0(sw_r[1]) + sw_r[0];
    w_t     = (round_r < ROUND_W'(BLOCK_WORDS)) ? rd_data : w_sched;
    ch      = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj     = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1      = v_r[7] + bsig1(v_r[4]) + ch + SHB_K[round_r] + w_t;
    t2      = bsig0(v_r[0]) + maj;
  end

  // Sequence one job
  always_comb begin
    state_nxt    = state_r;
    round_nxt    = round_r;
    idx_nxt      = idx_r;
    cmd_nxt      = cmd_r;
    cv_nxt       = cv_r;
    v_nxt        = v_r;
    sw_nxt       = sw_r;
    back_req.pop = 1'b0;
    // Prefetch the next block word; the RAM returns it in the next cycle
    back_req.rd_word = (state_r == BK_ROUND) ? round_r[WORD_IDX_W-1:0] + 1'b1 : '0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          cmd_nxt   = head_cmd;
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        if (cmd_r.init) begin
          cv_nxt = SHB_IV;
        end
        v_nxt     = cv_nxt;
        round_nxt = '0;
        idx_nxt   = '0;
        state_nxt = cmd_r.compress ? BK_ROUND : BK_EMIT;
      end
      BK_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          sw_nxt[i] = sw_r[i+1];
        end
        sw_nxt[BLOCK_WORDS-1] = w_t;
        v_nxt[7]  = v_r[6];
        v_nxt[6]  = v_r[5];
        v_nxt[5]  = v_r[4];
        v_nxt[4]  = v_r[3] + t1;
        v_nxt[3]  = v_r[2];
        v_nxt[2]  = v_r[1];
        v_nxt[1]  = v_r[0];
        v_nxt[0]  = t1 + t2;
        round_nxt = round_r + 1'b1;
        if (round_r == ROUND_W'(ROUNDS - 1)) begin
          state_nxt = BK_FINAL;
        end
      end
      BK_FINAL: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          cv_nxt[i] = cv_r[i] + v_r[i];
        end
        if (cmd_r.emit) begin
          state_nxt = BK_EMIT;
        end else begin
          back_req.pop = 1'b1;
          state_nxt    = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 1'b1;
          if (last_idx) begin
            back_req.pop = 1'b1;
            state_nxt    = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control state and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cv_r    <= SHB_IV;
    end else begin
      state_r <= state_nxt;
      cv_r    <= cv_nxt;
    end
  end

  // Working variables, schedule window and counters
  always_ff @(posedge clk) begin
    round_r <= round_nxt;
    idx_r   <= idx_nxt;
    cmd_r   <= cmd_nxt;
    v_r     <= v_nxt;
    sw_r    <= sw_nxt;
  end

endmodule

`default_nettype wire

FILE: design/sha256_block_hasher_core.sv
// SHA-256 block hasher core: padded 32-bit message word beats in, eight
// digest word beats out. Words are taken one per cycle into a two-slot block
// buffer as long as a slot is free; each full 16-word block then passes the
// compression engine in order: job pickup, setup, 64 rounds at one round per
// cycle, then the feed-forward. The words of the next block can fill the other
// slot meanwhile, so the sustained rate is set by the single round unit.
// A final word that ends on a partial block goes through pickup and setup
// only, before its eight digest beats, most significant word first, with tlast on
// the eighth. tuser marks the first word of a message and reloads the
// standard initial hash; words before a start continue from the current
// chaining value. No clearing pass after reset. Depends on shb_pkg, shb_front,
// shb_queue, shb_back and the defines.
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_block_hasher_core_defines.svh"

module sha256_block_hasher_core import shb_pkg::*; #(
  parameter int QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] message_word
  input  wire logic        in_tuser,   // [0] starts_message
  input  wire logic        in_tlast,   // ends_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] digest_word
  output logic             out_tlast   // last_digest_word
);

  shb_front_req_t front_req;
  shb_back_req_t  back_req;
  shb_q_stat_t    q_stat;
  shb_cmd_t       head_cmd;
  shb_word_t      rd_data;

  // Accept and classify word beats
  shb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .front_req (front_req)
  );

  // Hold gathered blocks until the engine takes them
  shb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .front_req (front_req),
    .back_req  (back_req),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .rd_data   (rd_data)
  );

  // Compress blocks and send the digest
  shb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_cmd   (head_cmd),
    .rd_data    (rd_data),
    .back_req   (back_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `SHB_ASSERT(a_no_push_full, !(front_req.push && q_stat.full), "job pushed into full queue")
  `SHB_ASSERT(a_no_pop_empty, !(back_req.pop && q_stat.empty), "job popped from empty queue")
  `SHB_ASSERT(a_emit_owns_slot, out_tvalid |-> !q_stat.empty, "digest beat without queued job")
  `SHB_ASSERT(a_gap_after_last, (out_tvalid && out_tready && out_tlast) |=> !out_tvalid, "beat after last digest word")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for sha256_block_hasher_core: padded message word beats go in,
// and digest beats are checked against an in-bench SHA-256 predictor.
// Depends on shb_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int WW          = shb_pkg::WORD_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 800;
  localparam int CALM_ITEMS  = 25;
  localparam int ITEM_COUNT  = 110;

  // Round constants, entry 0 in the top bits
  localparam logic [64*32-1:0] ROUND_K_FLAT = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Initial hash, word 0 in the top bits
  localparam logic [8*32-1:0] INIT_HASH_FLAT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  typedef struct packed {
    logic [WW-1:0] word;
    logic          start;
    logic          last;
  } msg_beat_t;

  typedef struct packed {
    logic [WW-1:0] word;
    logic          last;
  } digest_beat_t;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic [WW-1:0] in_tdata   = '0;
  logic          in_tuser   = 1'b0;
  logic          in_tlast   = 1'b0;
  logic          out_tready = 1'b0;
  logic          in_tready;
  logic          out_tvalid;
  logic [WW-1:0] out_tdata;
  logic          out_tlast;

  msg_beat_t    msg_beat_q[$];
  digest_beat_t digest_expect_q[$];
  msg_beat_t    next_beat;
  digest_beat_t want_beat;

  // Predictor state
  logic [WW-1:0] chain_hash [0:7];
  logic [WW-1:0] msg_window [0:15];
  logic [3:0]    word_slot;

  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  words_accepted = 0;
  int  in_gap_left    = 0;
  int  out_stall_left = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  in_beat_done   = 1'b0;
  bit  calm_phase     = 1'b0;

  sha256_block_hasher_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WW-1:0] ror32(input logic [WW-1:0] x, input int n);
    return (x >> n) | (x << (WW - n));
  endfunction

  // Run one 64-round compression over the gathered block and fold it into the chain
  function automatic void compress_window();
    logic [WW-1:0] w [0:63];
    logic [WW-1:0] v [0:7];
    logic [WW-1:0] x, y, t1, t2, ch, maj;
    for (int t = 0; t < 16; t++) w[t] = msg_window[t];
    for (int t = 16; t < 64; t++) begin
      x = w[t-15];
      y = w[t-2];
      w[t] = (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10)) + w[t-7]
           + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int t = 0; t < 64; t++) begin
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
          + ROUND_K_FLAT[(63-t)*32 +: 32] + w[t];
      t2  = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
  endfunction

  function automatic void load_init_hash();
    for (int i = 0; i < 8; i++) chain_hash[i] = INIT_HASH_FLAT[(7-i)*32 +: 32];
  endfunction

  // Update the predicted state for one accepted word beat; queue the digest on an end
  function automatic void predict_digest(input logic [WW-1:0] word, input logic start,
                                         input logic last);
    digest_beat_t d;
    if (start) begin
      load_init_hash();
      word_slot = '0;
    end
    msg_window[word_slot] = word;
    word_slot = word_slot + 4'd1;
    if (word_slot == 4'd0) compress_window();
    if (last) begin
      word_slot = '0;
      for (int i = 0; i < 8; i++) begin
        d.word = chain_hash[i];
        d.last = (i == 7);
        digest_expect_q.insert(digest_expect_q.size(), d);
      end
    end
  endfunction

  function automatic logic [WW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_beat(input logic [WW-1:0] word, input logic start, input logic last);
    msg_beat_t b;
    b.word  = word;
    b.start = start;
    b.last  = last;
    msg_beat_q.insert(msg_beat_q.size(), b);
  endtask

  // Queue a run of random words; flag the first and last as asked
  task automatic add_run(input int len, input bit with_start, input bit with_end);
    for (int i = 0; i < len; i++)
      add_beat(pick_word(), with_start && (i == 0), with_end && (i == len - 1));
  endtask

  // Capture accepted input beats and predict their results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_beat_done = 1'b1;
      words_accepted++;
      predict_digest(in_tdata, in_tuser, in_tlast);
    end
  end

  // Drive input beats, with random gaps until the last stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_beat_done) begin
      // hold the beat until it is taken
    end else begin
      in_beat_done = 1'b0;
      calm_phase   = (msg_beat_q.size() < CALM_ITEMS);
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (msg_beat_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        in_gap_left = $urandom_range(1, 12) - 1;
        in_tvalid <= 1'b0;
      end else begin
        next_beat = msg_beat_q.pop_front();
        in_tdata  <= next_beat.word;
        in_tuser  <= next_beat.start;
        in_tlast  <= next_beat.last;
        in_tvalid <= 1'b1;
      end
    end
  end

  // Drive out_tready: random stalls until the last stretch, plus one long hold-off once 40 words are taken
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && words_accepted >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_stall_left--;
      out_tready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
      out_stall_left = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check each digest beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_expect_q.size() == 0) begin
        $error("digest_word: expected none, got %h", out_tdata);
        fail_count++;
      end else begin
        want_beat = digest_expect_q.pop_front();
        if (out_tdata !== want_beat.word) begin
          $error("digest_word: expected %h, got %h", want_beat.word, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want_beat.last) begin
          $error("last_digest_word: expected %0b, got %0b", want_beat.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sha256_block_hasher_core");
      $finish;
    end
  end

  initial begin
    int target;
    int len;
    load_init_hash();
    for (int i = 0; i < 16; i++) msg_window[i] = '0;
    word_slot = '0;

    // Padded "abc": one full block, start on word 0, end on word 15
    add_beat(32'h61626380, 1'b1, 1'b0);
    for (int i = 1; i < 15; i++) add_beat(32'h00000000, 1'b0, 1'b0);
    add_beat(32'h00000018, 1'b0, 1'b1);
    // Start and end on one word: digest of a partial block is the initial hash
    add_beat(32'hffffffff, 1'b1, 1'b1);
    // Restart mid-block, then end on a partial block
    add_beat(32'hffffffff, 1'b1, 1'b0);
    add_beat(32'h00000000, 1'b0, 1'b0);
    add_beat(32'h80000000, 1'b1, 1'b1);
    // Missing start: keep chaining from the current value
    add_beat(32'hffffffff, 1'b0, 1'b1);

    // Random part: mostly well-formed messages, some broken ones; leave room for
    // the overshoot of the last run and the closing message
    target = ITEM_COUNT - 24;
    while (msg_beat_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_run(($urandom_range(0, 4) == 0) ? 32 : 16, 1'b1, 1'b1);
        6: add_run($urandom_range(1, 15), 1'b1, 1'b1);
        7: add_run($urandom_range(1, 15), 1'b1, 1'b0);
        8: add_run(16 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15)),
                   1'b0, 1'b1);
        default: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            add_beat(pick_word(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
      endcase
    end
    // Close with a clean message so the calm stretch ends on a digest
    add_run(16, 1'b1, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (msg_beat_q.size() != 0 || in_tvalid) @(posedge clk);
    while (digest_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS sha256_block_hasher_core");
    end else begin
      $display("FAIL sha256_block_hasher_core");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/shb_pkg.sv
design/shb_ram.sv
design/shb_queue.sv
design/shb_front.sv
design/shb_back.sv
design/sha256_block_hasher_core.sv
tb/tb_top.sv
